// ===== hw/rtl/taylor_sine_cosine_defines.svh =====
// ----------------------------------------------------------------------------
// taylor_sine_cosine_defines.svh
// Assertion macros used by the sine/cosine port checks in tsc_chk.
// ----------------------------------------------------------------------------
`ifndef TAYLOR_SINE_COSINE_DEFINES_SVH
`define TAYLOR_SINE_COSINE_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define TSC_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define TSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after a reset edge.
`define TSC_ASSERT_RESET(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !(rst_n) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tsc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsc_pkg
// Widths, constants and the pipeline tag shared by the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int ANG_W     = 31;  // Q3.28 angle
    localparam int OUT_W     = 31;  // Q1.30 result
    localparam int X2_W      = 31;  // x^2 in Q26, unsigned, up to 16.0
    localparam int ACC_W     = 36;  // Horner accumulator, Q30, |acc| < 32
    localparam int MUL_ACC_W = 33;  // acc fed to a level multiply, |acc| < 4
    localparam int SIN_ACC_W = 34;  // acc fed to the sine multiply, |acc| < 8
    localparam int T_W       = 37;  // signed term x2*acc >> 26
    localparam int MAG_W     = 36;  // term magnitude and quotient width
    localparam int T_SHIFT   = 26;
    localparam int X2_SHIFT  = 30;
    localparam int SIN_SHIFT = 28;
    localparam int FIN_W     = 37;  // pre-saturation result
    localparam int LVL_STAGES = 6;

    localparam logic [ACC_W-1:0] ONE_ACC = ACC_W'(64'd1 << 30);

    localparam logic signed [FIN_W-1:0] SAT_HI = 37'sd1073741823;
    localparam logic signed [FIN_W-1:0] SAT_LO = -37'sd1073741824;

    localparam logic OP_SINE   = 1'b0;
    localparam logic OP_COSINE = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic signed [ANG_W-1:0] x;
        logic [X2_W-1:0]         x2;
        logic                    cosine;
    } t_tag;

endpackage

// ===== hw/rtl/tsc_level.sv =====
// ----------------------------------------------------------------------------
// tsc_level
// One Horner level: acc_out = 1 - trunc(((x2*acc) >> 26) / d), six stages.
// ----------------------------------------------------------------------------
module tsc_level #(
    parameter int K = 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  tsc_pkg::t_tag                     i_tag,
    input  logic signed [tsc_pkg::ACC_W-1:0]  i_acc,
    output tsc_pkg::t_tag                     o_tag,
    output logic signed [tsc_pkg::ACC_W-1:0]  o_acc
);

    localparam int MAG_W = tsc_pkg::MAG_W;
    localparam int HALF  = MAG_W / 2;
    localparam int PP_W  = HALF + MAG_W;
    localparam int SUM_W = 2 * MAG_W;
    localparam int D_SIN = (2 * K) * (2 * K + 1);
    localparam int D_COS = (2 * K - 1) * (2 * K);
    localparam int D_W   = $clog2(D_SIN + 1);

    // floor(2^MAG_W / d): estimate is exact or one low for any term below 2^MAG_W
    localparam logic [MAG_W-1:0] M_SIN = MAG_W'((64'd1 << MAG_W) / 64'(D_SIN));
    localparam logic [MAG_W-1:0] M_COS = MAG_W'((64'd1 << MAG_W) / 64'(D_COS));
    localparam logic [D_W-1:0]   DV_SIN = D_W'(D_SIN);
    localparam logic [D_W-1:0]   DV_COS = D_W'(D_COS);

    tsc_pkg::t_tag r_tag [tsc_pkg::LVL_STAGES];

    logic signed [tsc_pkg::T_W-1:0]   r_t;
    logic                             r_neg2, r_neg3, r_neg4, r_neg5;
    logic [MAG_W-1:0]                 r_mag2, r_mag3, r_mag4, r_mag5;
    logic [PP_W-1:0]                  r_plo, r_phi;
    logic [MAG_W-1:0]                 r_q0, r_qd;
    logic [tsc_pkg::ACC_W-1:0]        r_base;
    logic signed [tsc_pkg::ACC_W-1:0] r_acc;

    logic signed [tsc_pkg::X2_W+tsc_pkg::MUL_ACC_W:0] w_prod;
    logic [MAG_W-1:0]                 n_mag, w_m, n_q0, n_qd, w_rem;
    logic [PP_W-1:0]                  n_plo, n_phi;
    logic [SUM_W-1:0]                 w_sum;
    logic [D_W-1:0]                   w_d5, w_d6;
    logic [tsc_pkg::ACC_W-1:0]        n_base, n_acc;
    logic                             w_bump;

    // stage 1: term product
    assign w_prod = $signed({1'b0, i_tag.x2}) * $signed(i_acc[tsc_pkg::MUL_ACC_W-1:0]);

    // stage 2: magnitude for truncating division
    assign n_mag = r_t[tsc_pkg::T_W-1] ? MAG_W'(-r_t) : MAG_W'(r_t);

    // stage 3: reciprocal partial products
    assign w_m   = r_tag[1].cosine ? M_COS : M_SIN;
    assign n_plo = r_mag2[HALF-1:0] * w_m;
    assign n_phi = r_mag2[MAG_W-1:HALF] * w_m;

    // stage 4: quotient estimate
    assign w_sum = SUM_W'(r_plo) + (SUM_W'(r_phi) << HALF);
    assign n_q0  = w_sum[SUM_W-1:MAG_W];

    // stage 5: back-multiply, and 1 -/+ estimate in parallel
    assign w_d5   = r_tag[3].cosine ? DV_COS : DV_SIN;
    assign n_qd   = MAG_W'(r_q0 * w_d5);
    assign n_base = r_neg4 ? (tsc_pkg::ONE_ACC + tsc_pkg::ACC_W'(r_q0))
                           : (tsc_pkg::ONE_ACC - tsc_pkg::ACC_W'(r_q0));

    // stage 6: one-step correction of the estimate
    assign w_d6   = r_tag[4].cosine ? DV_COS : DV_SIN;
    assign w_rem  = r_mag5 - r_qd;
    assign w_bump = (w_rem >= MAG_W'(w_d6));
    assign n_acc  = !w_bump ? r_base
                  : (r_neg5 ? r_base + tsc_pkg::ACC_W'(1) : r_base - tsc_pkg::ACC_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < tsc_pkg::LVL_STAGES; i++) begin
                r_tag[i].valid <= 1'b0;
            end
        end else if (i_en) begin
            r_tag[0] <= i_tag;
            for (int i = 1; i < tsc_pkg::LVL_STAGES; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= w_prod[tsc_pkg::T_SHIFT+tsc_pkg::T_W-1:tsc_pkg::T_SHIFT];
            r_neg2 <= r_t[tsc_pkg::T_W-1];
            r_mag2 <= n_mag;
            r_neg3 <= r_neg2;
            r_mag3 <= r_mag2;
            r_plo  <= n_plo;
            r_phi  <= n_phi;
            r_neg4 <= r_neg3;
            r_mag4 <= r_mag3;
            r_q0   <= n_q0;
            r_neg5 <= r_neg4;
            r_mag5 <= r_mag4;
            r_qd   <= n_qd;
            r_base <= n_base;
            r_acc  <= n_acc;
        end
    end

    assign o_tag = r_tag[tsc_pkg::LVL_STAGES-1];
    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/taylor_sine_cosine.sv =====
// Pipeline of 6*NUM_TERMS-2 register stages. Throughput: one request per cycle while
// the output is not stalled, set by the fully pipelined Horner levels (six stages each)
// and the 36-bit quotient estimate split into two partial products per level.
// Reset: synchronous active-low, clears every stage valid bit; no state otherwise.
// ----------------------------------------------------------------------------
// taylor_sine_cosine
// Fixed-term Maclaurin sine/cosine, Q3.28 angle in, saturated Q1.30 out.
// ----------------------------------------------------------------------------
module taylor_sine_cosine #(
    parameter int NUM_TERMS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [tsc_pkg::ANG_W-1:0]    i_angle,
    input  logic                                i_opcode,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [tsc_pkg::OUT_W-1:0]    o_value
);

    // Pipeline map:
    //   A    input register
    //   B    x2 = floor(x*x / 2^30)
    //   L*   NUM_TERMS-1 Horner levels, k = NUM_TERMS-1 first
    //   F1   sine: x*acc >> 28, cosine: acc
    //   F2   saturation into the output register
    // The whole pipe advances together; it moves whenever the output slot is
    // empty or its result is being taken, so a stall freezes every stage, bubbles included.

    localparam int LEVELS = NUM_TERMS - 1;

    logic w_adv;

    tsc_pkg::t_tag r_a, r_b, n_b;
    tsc_pkg::t_tag w_tag [NUM_TERMS];
    logic signed [tsc_pkg::ACC_W-1:0] w_acc [NUM_TERMS];

    logic signed [2*tsc_pkg::ANG_W-1:0]                  w_xsq;
    logic signed [tsc_pkg::ANG_W+tsc_pkg::SIN_ACC_W-1:0] w_sprod;
    logic signed [tsc_pkg::FIN_W-1:0]                    n_fin, r_fin;
    logic                                                r_fin_valid;
    logic signed [tsc_pkg::OUT_W-1:0]                    n_value, r_value;
    logic                                                r_out_valid;

    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    // Stage A: register the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a.valid <= 1'b0;
        end else if (w_adv) begin
            r_a.valid  <= i_in_valid;
            r_a.x      <= i_angle;
            r_a.x2     <= '0;
            r_a.cosine <= (i_opcode == tsc_pkg::OP_COSINE);
        end
    end

    // Stage B: square is non-negative, bits above 2^60 never set
    assign w_xsq = r_a.x * r_a.x;

    always_comb begin
        n_b    = r_a;
        n_b.x2 = w_xsq[tsc_pkg::X2_SHIFT+tsc_pkg::X2_W-1:tsc_pkg::X2_SHIFT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (w_adv) begin
            r_b <= n_b;
        end
    end

    // Horner chain, innermost level starts from 1.0
    assign w_tag[0] = r_b;
    assign w_acc[0] = $signed(tsc_pkg::ONE_ACC);

    for (genvar j = 0; j < LEVELS; j++) begin : g_level
        tsc_level #(
            .K (NUM_TERMS - 1 - j)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_tag   (w_tag[j]),
            .i_acc   (w_acc[j]),
            .o_tag   (w_tag[j+1]),
            .o_acc   (w_acc[j+1])
        );
    end

    // F1: sine needs one more multiply; the sine sum stays below 8.0 so the
    // low bits of acc carry it exactly
    assign w_sprod = w_tag[NUM_TERMS-1].x
                   * $signed(w_acc[NUM_TERMS-1][tsc_pkg::SIN_ACC_W-1:0]);
    assign n_fin = w_tag[NUM_TERMS-1].cosine
                 ? tsc_pkg::FIN_W'(w_acc[NUM_TERMS-1])
                 : w_sprod[tsc_pkg::SIN_SHIFT+tsc_pkg::FIN_W-1:tsc_pkg::SIN_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (w_adv) begin
            r_fin_valid <= w_tag[NUM_TERMS-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin <= n_fin;
        end
    end

    // F2: clamp to Q1.30; cosine of zero arrives as exactly 1.0 and is clamped to SAT_HI
    always_comb begin
        if (r_fin > tsc_pkg::SAT_HI) begin
            n_value = tsc_pkg::OUT_W'(tsc_pkg::SAT_HI);
        end else if (r_fin < tsc_pkg::SAT_LO) begin
            n_value = tsc_pkg::OUT_W'(tsc_pkg::SAT_LO);
        end else begin
            n_value = tsc_pkg::OUT_W'(r_fin);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_value <= n_value;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

endmodule

// ===== hw/rtl/tsc_chk.sv =====
// ----------------------------------------------------------------------------
// tsc_chk
// Port-level checks on the sine/cosine pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`include "taylor_sine_cosine_defines.svh"

module tsc_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic signed [tsc_pkg::ANG_W-1:0] i_angle,
    input logic                             i_opcode,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic signed [tsc_pkg::OUT_W-1:0] o_value
);

    // stalled result must hold
    `TSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_value), "stalled result changed")

    // empty output slot always lets a request in
    `TSC_ASSERT_HOLD(a_ready_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready, "ready low with output empty")

    // a blocked result freezes the pipe
    `TSC_ASSERT_HOLD(a_ready_stall, i_clk, i_rst_n, o_out_valid && !i_out_ready, !o_in_ready, "request taken while output stalled")

    `TSC_ASSERT_RESET(a_reset_clear, i_clk, i_rst_n, !o_out_valid, "result valid after reset")

endmodule

bind taylor_sine_cosine tsc_chk u_tsc_chk (.*);

// ===== tb/tsc_checker.sv =====
// ----------------------------------------------------------------------------
// tsc_checker
// Watches both channels of the sine/cosine pipeline. Each accepted request is
// turned into an expected Q1.30 value by a bit-exact Horner model. Each
// accepted result is compared in order with the oldest expected value.
// ----------------------------------------------------------------------------
module tsc_checker #(
    parameter int NUM_TERMS = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [tsc_pkg::ANG_W-1:0]    i_angle,
    input  logic                                i_opcode,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [tsc_pkg::OUT_W-1:0]    i_value,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // wide enough that no intermediate product can wrap
    localparam int WIDE_W = 128;
    localparam logic signed [WIDE_W-1:0] ONE_Q30 = 128'sd1 <<< 30;

    typedef struct {
        logic signed [tsc_pkg::ANG_W-1:0] angle;
        logic                             opcode;
        logic signed [tsc_pkg::OUT_W-1:0] value;
    } t_sincos_expect;

    t_sincos_expect expected_values [$];

    // Fixed-term Maclaurin sum in nested form, then saturation to Q1.30.
    function automatic logic signed [tsc_pkg::OUT_W-1:0] taylor_value(
        input logic signed [tsc_pkg::ANG_W-1:0] ang,
        input logic                             op
    );
        logic signed [WIDE_W-1:0] x;
        logic signed [WIDE_W-1:0] x2;
        logic signed [WIDE_W-1:0] acc;
        logic signed [WIDE_W-1:0] term;
        logic signed [WIDE_W-1:0] div;
        logic signed [WIDE_W-1:0] sum;
        int k;
        x   = ang;
        x2  = (x * x) >>> tsc_pkg::X2_SHIFT;
        acc = ONE_Q30;
        for (k = NUM_TERMS - 1; k >= 1; k--) begin
            if (op == tsc_pkg::OP_COSINE) begin
                div = (2 * k - 1) * (2 * k);
            end else begin
                div = (2 * k) * (2 * k + 1);
            end
            term = (x2 * acc) >>> tsc_pkg::T_SHIFT;
            acc  = ONE_Q30 - term / div;   // signed divide truncates toward zero
        end
        if (op == tsc_pkg::OP_COSINE) begin
            sum = acc;
        end else begin
            sum = (x * acc) >>> tsc_pkg::SIN_SHIFT;
        end
        if (sum > tsc_pkg::SAT_HI) begin
            sum = tsc_pkg::SAT_HI;
        end else if (sum < tsc_pkg::SAT_LO) begin
            sum = tsc_pkg::SAT_LO;
        end
        return sum[tsc_pkg::OUT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("%t ERROR %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_sincos_expect exp_item;
        if (!i_rst_n) begin
            expected_values.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                exp_item.angle  = i_angle;
                exp_item.opcode = i_opcode;
                exp_item.value  = taylor_value(i_angle, i_opcode);
                expected_values.push_back(exp_item);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_values.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value %0d", i_value));
                end else begin
                    exp_item = expected_values.pop_front();
                    if (i_value !== exp_item.value) begin
                        report_mismatch($sformatf(
                            "angle %0d op %0d: value %0d, expected %0d",
                            exp_item.angle, exp_item.opcode, i_value, exp_item.value));
                    end
                end
            end
            o_pending = expected_values.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Top of the sine/cosine pipeline test. Drives corner angles for both
// opcodes, then random angles under three idle patterns, with one pause
// until the pipeline drains. Checking is done by tsc_checker.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TERMS    = 12;
    localparam int LATENCY      = 6 * NUM_TERMS - 3;
    localparam int RANDOM_ITEMS = 560;                // per idle phase

    // Q3.28 angle constants
    localparam logic signed [tsc_pkg::ANG_W-1:0] ANG_MAX     = 31'sd1073741823;
    localparam logic signed [tsc_pkg::ANG_W-1:0] ANG_MIN     = -31'sd1073741824;
    localparam logic signed [tsc_pkg::ANG_W-1:0] ANG_ONE     = 31'sd268435456;
    localparam logic signed [tsc_pkg::ANG_W-1:0] ANG_HALF_PI = 31'sd421657428;
    localparam logic signed [tsc_pkg::ANG_W-1:0] ANG_PI      = 31'sd843314857;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic signed [tsc_pkg::ANG_W-1:0] angle;
    logic                             opcode;
    logic                             out_valid;
    logic                             out_ready;
    logic signed [tsc_pkg::OUT_W-1:0] value;

    int fail_count;
    int pending;
    int snd_idle;   // percent of cycles the sender holds back
    int rcv_idle;   // percent of cycles the receiver stalls

    always #10 clk = ~clk;

    taylor_sine_cosine #(
        .NUM_TERMS (NUM_TERMS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_angle     (angle),
        .i_opcode    (opcode),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_value     (value)
    );

    tsc_checker #(
        .NUM_TERMS (NUM_TERMS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_angle      (angle),
        .i_opcode     (opcode),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_value      (value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Corner angles: zero, one LSB either side, both range ends, +-1.0,
    // +-pi/2 (sine near full scale), +-pi.
    function automatic logic signed [tsc_pkg::ANG_W-1:0] corner_angle(input int idx);
        case (idx)
            0:       return '0;
            1:       return 31'sd1;
            2:       return -31'sd1;
            3:       return ANG_MAX;
            4:       return ANG_MIN;
            5:       return ANG_ONE;
            6:       return -ANG_ONE;
            7:       return ANG_HALF_PI;
            8:       return -ANG_HALF_PI;
            9:       return ANG_PI;
            default: return -ANG_PI;
        endcase
    endfunction

    // Random angle: uniform over all bit patterns in four of ten draws, plus clusters
    // near zero, near +-pi/2 (saturation edge), near +-pi and at the ends.
    function automatic logic signed [tsc_pkg::ANG_W-1:0] random_angle();
        logic signed [tsc_pkg::ANG_W-1:0] a;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: a = tsc_pkg::ANG_W'($urandom());
            4, 5:       a = tsc_pkg::ANG_W'($urandom_range(0, 1 << 20)) - 31'sd524288;
            6, 7:       a = ANG_HALF_PI + tsc_pkg::ANG_W'($urandom_range(0, 1 << 16))
                          - 31'sd32768;
            8:          a = ANG_PI - tsc_pkg::ANG_W'($urandom_range(0, 1 << 24));
            default:    a = ANG_MAX - tsc_pkg::ANG_W'($urandom_range(0, 255));
        endcase
        if ((sel >= 6) && $urandom_range(0, 1)) begin
            a = -a;   // mirror the clusters onto negative angles
        end
        return a;
    endfunction

    // One request: random idle gap, then hold valid and payload until taken.
    // Valid is only dropped on an idle cycle, so a back-to-back request never
    // sees a low-then-high pair in one time step.
    task automatic send_request(
        input logic signed [tsc_pkg::ANG_W-1:0] ang,
        input logic                             op
    );
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle) begin
            in_valid <= 1'b0;
            angle    <= tsc_pkg::ANG_W'($urandom());   // junk while idle
            @(negedge clk);
        end
        in_valid <= 1'b1;
        angle    <= ang;
        opcode   <= op;
        do @(posedge clk); while (!in_ready);
    endtask

    // Receiver: one ready decision per cycle, made at the falling edge.
    initial begin : receiver
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    initial begin : stimulus
        int phase;
        int i;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        angle    = '0;
        opcode   = tsc_pkg::OP_SINE;
        snd_idle = 19;
        rcv_idle = 72;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // corner angles for both sine and cosine
        for (i = 0; i < 11; i++) begin
            send_request(corner_angle(i), tsc_pkg::OP_SINE);
            send_request(corner_angle(i), tsc_pkg::OP_COSINE);
        end

        // phase 0: sender mostly busy, receiver mostly stalled
        // phase 1: the reverse; phase 2: no idling at all
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin snd_idle = 19; rcv_idle = 72; end
                1:       begin snd_idle = 72; rcv_idle = 19; end
                default: begin snd_idle = 0;  rcv_idle = 0;  end
            endcase
            for (i = 0; i < RANDOM_ITEMS; i++) begin
                send_request(random_angle(), logic'($urandom_range(0, 1)));
                if ((phase == 0) && (i == RANDOM_ITEMS / 2)) begin
                    // hold the sender until the pipeline has fully drained
                    @(negedge clk);
                    in_valid <= 1'b0;
                    while (pending != 0) @(negedge clk);
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY + 30) @(posedge clk);   // catch any stray result

        if ((fail_count == 0) && (pending == 0)) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Hard stop: far beyond the slowest legal run of 1702 requests
    initial begin : watchdog
        #6_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
